>>> rtl/wsd_pkg.sv
// Package for the WebSocket frame deframer: parser phase encoding, result
// kinds, error codes, header constants and the per-byte result struct.
// Has no dependencies; every other file of the block imports it.
package wsd_pkg;

  // Length codes in the second header byte that select an extended length.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Index of the last byte of each multi-byte header field.
  localparam logic [2:0] LEN16_LAST = 3'd1;
  localparam logic [2:0] LEN64_LAST = 3'd7;
  localparam int unsigned MASK_KEY_BYTES = 4;
  localparam logic [2:0] MASK_LAST = 3'(MASK_KEY_BYTES - 1);

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_B0    = 6'b000001,
    PH_B1    = 6'b000010,
    PH_LEN16 = 6'b000100,
    PH_LEN64 = 6'b001000,
    PH_MASK  = 6'b010000,
    PH_DATA  = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_RSV_BIT  = 2'd1,
    ERR_RSV_OP   = 2'd2,
    ERR_CTRL_EXT = 2'd3
  } err_e;

  // One result item as it leaves the parser.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic        fin;
    logic        done;
    err_e        err;
  } res_t;

  // Opcodes defined by the protocol: continuation, text, binary, close,
  // ping and pong.
  function automatic logic op_is_defined(input logic [3:0] op);
    return (op <= 4'd2) || ((op >= 4'd8) && (op <= 4'd10));
  endfunction

endpackage

>>> rtl/wsd_parser.sv
// Frame header parser and payload unmasker for the WebSocket deframer.
// Holds the frame state and updates it once for each committed byte.
// Depends on wsd_pkg.
module wsd_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic [7:0]     byte_i,
  output wsd_pkg::res_t  res_o
);
  import wsd_pkg::*;

  phase_e      phase_q,   phase_d;
  logic [3:0]  opcode_q,  opcode_d;
  logic        fin_q,     fin_d;
  logic        masked_q,  masked_d;
  logic [63:0] len_q,     len_d;
  logic [63:0] cnt_q,     cnt_d;
  logic [2:0]  hbc_q,     hbc_d;
  logic [31:0] key_q,     key_d;
  logic        failed_q,  failed_d;
  err_e        err_q,     err_d;

  logic [6:0]  len7;
  logic [3:0]  op;
  logic [63:0] cnt_inc;
  logic [7:0]  key_byte;
  kind_e       kind;
  logic [7:0]  data;
  logic        done;

  assign len7    = byte_i[6:0];
  assign op      = byte_i[3:0];
  assign cnt_inc = cnt_q + 64'd1;

  // Key bytes are used first byte first, cycling every four payload bytes.
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    fin_d    = fin_q;
    masked_d = masked_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    hbc_d    = hbc_q;
    key_d    = key_q;
    failed_d = failed_q;
    err_d    = err_q;
    kind     = KIND_HDR;
    data     = 8'd0;
    done     = 1'b0;

    if (!failed_q) begin
      case (phase_q)
        PH_B1: begin
          masked_d = byte_i[7];
          hbc_d    = 3'd0;
          if ((len7 >= LEN_EXT16) && opcode_q[3]) begin
            failed_d = 1'b1;
            err_d    = ERR_CTRL_EXT;
          end else if (len7 == LEN_EXT16) begin
            len_d   = 64'd0;
            phase_d = PH_LEN16;
          end else if (len7 == LEN_EXT64) begin
            len_d   = 64'd0;
            phase_d = PH_LEN64;
          end else begin
            len_d = {57'd0, len7};
            cnt_d = 64'd0;
            if (byte_i[7]) begin
              phase_d = PH_MASK;
            end else if (len7 == 7'd0) begin
              done    = 1'b1;
              phase_d = PH_B0;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_LEN16, PH_LEN64: begin
          len_d = {len_q[55:0], byte_i};
          if (hbc_q >= ((phase_q == PH_LEN16) ? LEN16_LAST : LEN64_LAST)) begin
            hbc_d = 3'd0;
            cnt_d = 64'd0;
            if (masked_q) begin
              phase_d = PH_MASK;
            end else if (len_d == 64'd0) begin
              done    = 1'b1;
              phase_d = PH_B0;
            end else begin
              phase_d = PH_DATA;
            end
          end else begin
            hbc_d = hbc_q + 3'd1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[23:0], byte_i};
          if (hbc_q >= MASK_LAST) begin
            hbc_d = 3'd0;
            cnt_d = 64'd0;
            if (len_q == 64'd0) begin
              done    = 1'b1;
              phase_d = PH_B0;
            end else begin
              phase_d = PH_DATA;
            end
          end else begin
            hbc_d = hbc_q + 3'd1;
          end
        end
        PH_DATA: begin
          kind  = KIND_DATA;
          data  = masked_q ? (byte_i ^ key_byte) : byte_i;
          cnt_d = cnt_inc;
          if (cnt_inc >= len_q) begin
            done    = 1'b1;
            cnt_d   = 64'd0;
            phase_d = PH_B0;
          end
        end
        default: begin
          if (byte_i[6:4] != 3'd0) begin
            failed_d = 1'b1;
            err_d    = ERR_RSV_BIT;
          end else if (!op_is_defined(op)) begin
            failed_d = 1'b1;
            err_d    = ERR_RSV_OP;
          end else begin
            fin_d    = byte_i[7];
            opcode_d = op;
            masked_d = 1'b0;
            len_d    = 64'd0;
            cnt_d    = 64'd0;
            hbc_d    = 3'd0;
            key_d    = 32'd0;
            phase_d  = PH_B1;
          end
        end
      endcase
    end

    if (failed_d) begin
      res_o = '{kind: KIND_FAIL, data: 8'd0, opcode: 4'd0, fin: 1'b0,
                done: 1'b0, err: err_d};
    end else begin
      res_o = '{kind: kind, data: data, opcode: opcode_d, fin: fin_d,
                done: done, err: ERR_NONE};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_B0;
      opcode_q <= 4'd0;
      fin_q    <= 1'b0;
      masked_q <= 1'b0;
      len_q    <= 64'd0;
      cnt_q    <= 64'd0;
      hbc_q    <= 3'd0;
      key_q    <= 32'd0;
      failed_q <= 1'b0;
      err_q    <= ERR_NONE;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      fin_q    <= fin_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      hbc_q    <= hbc_d;
      key_q    <= key_d;
      failed_q <= failed_d;
      err_q    <= err_d;
    end
  end

endmodule

>>> rtl/websocket_frame_deframer_unit.sv
// Top level of the WebSocket frame deframer: input register, parser and
// output register with valid/stall flow control.
// Depends on wsd_pkg and wsd_parser.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_stall_o  in_byte_i
//   out      output     out_valid_o / out_stall_i kind_o, out_byte_o,
//                                                frame_opcode_o, final_fragment_o,
//                                                frame_done_o, error_code_o
//
// A byte sits in the input register while the parser works on it, and its
// result is loaded into the output register when the byte advances, from
// where it transfers on the output channel. Throughput is one byte per cycle
// while the output does not stall, set by the single parser pass.
// Reset clears the input and output valid flags and returns the parser to
// the first header byte. A stall on the output holds the output register
// and, once the input register is also full, stalls the input channel.
module websocket_frame_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [3:0]  frame_opcode_o,
  output logic        final_fragment_o,
  output logic        frame_done_o,
  output logic [1:0]  error_code_o
);
  import wsd_pkg::*;

  logic   in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic   out_valid_q, out_valid_d;
  res_t   res_q;
  res_t   res;
  logic   adv;
  logic   in_load;

  // The byte in the input register moves on whenever the output register
  // is empty or its result is transferred in this cycle.
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_load    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_load) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset; they are qualified by the valid flags.
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_byte_q <= in_byte_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  // The parser commits its state only when the byte actually advances, so
  // a held byte is never parsed twice.
  wsd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  assign out_valid_o      = out_valid_q;
  assign kind_o           = res_q.kind;
  assign out_byte_o       = res_q.data;
  assign frame_opcode_o   = res_q.opcode;
  assign final_fragment_o = res_q.fin;
  assign frame_done_o     = res_q.done;
  assign error_code_o     = res_q.err;

endmodule

>>> test/websocket_frame_deframer_unit_tb.sv
// Self-checking testbench for websocket_frame_deframer_unit: drives framed byte streams,
// predicts every per-byte result and checks it against the output channel.
// Depends on wsd_pkg and the deframer RTL; needs no files or arguments.
module websocket_frame_deframer_unit_tb;
  import wsd_pkg::*;

  // Opcodes that the protocol defines. Anything else in the first header byte is a
  // reserved opcode.
  localparam logic [3:0] OP_CONT  = 4'd0;
  localparam logic [3:0] OP_TEXT  = 4'd1;
  localparam logic [3:0] OP_BIN   = 4'd2;
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;
  localparam logic [3:0] OP_PONG  = 4'd10;

  // Length encodings that the frame generator can choose from.
  localparam int LEN_MODE_SHORT = 0;
  localparam int LEN_MODE_EXT16 = 1;
  localparam int LEN_MODE_EXT64 = 2;

  // How the run ends. Only one reset is allowed, so a run can reach only one of the
  // sticky error codes. It can also end in a frame whose 64-bit length has its top
  // bit set, since the payload of such a frame never finishes.
  localparam int END_RSV_BIT  = 0;
  localparam int END_RSV_OP   = 1;
  localparam int END_CTRL_EXT = 2;
  localparam int END_HUGE_LEN = 3;

  localparam int RANDOM_ITEMS = 850;
  localparam int QUIET_FROM   = 760;
  localparam int PAUSE_AT     = 400;
  localparam int NOISE_BYTES  = 40;

  // Directed opening, in order:
  //  - a final text frame, unmasked, whose payload holds 00 and FF;
  //  - a non-final binary frame, masked, whose key and payload hold the extremes;
  //  - an empty final continuation frame, which ends on its length byte;
  //  - a fragmented, masked, empty ping, which ends on its last key byte.
  localparam logic [7:0] DIRECTED_BYTES [24] = '{
    8'h81, 8'h03, 8'h00, 8'hFF, 8'h5A,
    8'h02, 8'h85, 8'hFF, 8'h00, 8'hA5, 8'h3C, 8'hFF, 8'h00, 8'h12, 8'h34, 8'h56,
    8'h80, 8'h00,
    8'h09, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44
  };

  // Scoreboard. It keeps its own copy of the parser state. For each byte that enters
  // the block, it queues the result that the byte must produce.
  class deframe_scoreboard;
    phase_e      ph;
    logic [3:0]  op;
    logic        fin;
    logic        masked;
    logic [63:0] plen;
    logic [63:0] pcnt;
    logic [2:0]  hcnt;
    logic [31:0] key;
    logic        failed;
    err_e        err_code;
    res_t        predicted_results[$];
    int          mismatches;

    function new();
      ph         = PH_B0;
      op         = 4'd0;
      fin        = 1'b0;
      masked     = 1'b0;
      plen       = 64'd0;
      pcnt       = 64'd0;
      hcnt       = 3'd0;
      key        = 32'd0;
      failed     = 1'b0;
      err_code   = ERR_NONE;
      mismatches = 0;
    endfunction

    function int outstanding();
      return predicted_results.size();
    endfunction

    // The length is complete. Go on to the key or the payload, or end an empty
    // frame here. Returns 1 if the frame ends on this byte.
    function logic length_complete();
      hcnt = 3'd0;
      pcnt = 64'd0;
      if (masked) begin
        ph = PH_MASK;
      end else if (plen == 64'd0) begin
        ph = PH_B0;
        return 1'b1;
      end else begin
        ph = PH_DATA;
      end
      return 1'b0;
    endfunction

    function void note_byte(input logic [7:0] b);
      res_t       r;
      kind_e      k;
      logic [7:0] data;
      logic       done;
      logic [2:0] last;
      logic [1:0] idx;
      logic [7:0] kb;
      k    = KIND_HDR;
      data = 8'd0;
      done = 1'b0;
      if (!failed) begin
        case (ph)
          PH_B1: begin
            masked = b[7];
            hcnt   = 3'd0;
            if (b[6:0] >= LEN_EXT16 && op >= OP_CLOSE) begin
              failed   = 1'b1;
              err_code = ERR_CTRL_EXT;
            end else if (b[6:0] == LEN_EXT16) begin
              plen = 64'd0;
              ph   = PH_LEN16;
            end else if (b[6:0] == LEN_EXT64) begin
              plen = 64'd0;
              ph   = PH_LEN64;
            end else begin
              plen = 64'(b[6:0]);
              done = length_complete();
            end
          end
          PH_LEN16, PH_LEN64: begin
            last = (ph == PH_LEN16) ? LEN16_LAST : LEN64_LAST;
            plen = {plen[55:0], b};
            if (hcnt >= last) begin
              done = length_complete();
            end else begin
              hcnt = hcnt + 3'd1;
            end
          end
          PH_MASK: begin
            key = {key[23:0], b};
            if (hcnt >= MASK_LAST) begin
              hcnt = 3'd0;
              pcnt = 64'd0;
              if (plen == 64'd0) begin
                done = 1'b1;
                ph   = PH_B0;
              end else begin
                ph = PH_DATA;
              end
            end else begin
              hcnt = hcnt + 3'd1;
            end
          end
          PH_DATA: begin
            // The first key byte sits in the top of the key register.
            idx  = pcnt[1:0];
            kb   = 8'(key >> (8 * (3 - idx)));
            k    = KIND_DATA;
            data = masked ? (b ^ kb) : b;
            pcnt = pcnt + 64'd1;
            if (pcnt >= plen) begin
              done = 1'b1;
              pcnt = 64'd0;
              ph   = PH_B0;
            end
          end
          default: begin
            if (b[6:4] != 3'b000) begin
              failed   = 1'b1;
              err_code = ERR_RSV_BIT;
            end else if (!(b[3:0] inside {OP_CONT, OP_TEXT, OP_BIN,
                                          OP_CLOSE, OP_PING, OP_PONG})) begin
              failed   = 1'b1;
              err_code = ERR_RSV_OP;
            end else begin
              fin    = b[7];
              op     = b[3:0];
              masked = 1'b0;
              plen   = 64'd0;
              pcnt   = 64'd0;
              hcnt   = 3'd0;
              key    = 32'd0;
              ph     = PH_B1;
            end
          end
        endcase
      end
      if (failed) begin
        r.kind   = KIND_FAIL;
        r.data   = 8'd0;
        r.opcode = 4'd0;
        r.fin    = 1'b0;
        r.done   = 1'b0;
        r.err    = err_code;
      end else begin
        r.kind   = k;
        r.data   = data;
        r.opcode = op;
        r.fin    = fin;
        r.done   = done;
        r.err    = ERR_NONE;
      end
      predicted_results.push_back(r);
    endfunction

    function void check_result(input res_t got);
      res_t want;
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("MISMATCH: result with nothing predicted: kind=%0d byte=%02h op=%0d",
                   got.kind, got.data, got.opcode);
        end
        return;
      end
      want = predicted_results.pop_front();
      if (got.kind !== want.kind || got.data !== want.data || got.opcode !== want.opcode ||
          got.fin !== want.fin || got.done !== want.done || got.err !== want.err) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("MISMATCH: expected kind=%0d byte=%02h op=%0d fin=%0d done=%0d err=%0d",
                   want.kind, want.data, want.opcode, want.fin, want.done, want.err);
          $display("          actual   kind=%0d byte=%02h op=%0d fin=%0d done=%0d err=%0d",
                   got.kind, got.data, got.opcode, got.fin, got.done, got.err);
        end
      end
    endfunction
  endclass

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'd0;
  logic       out_stall = 1'b0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic [3:0] frame_opcode_o;
  logic       final_fragment_o;
  logic       frame_done_o;
  logic [1:0] error_code_o;

  // Set for the closing stretch of the run. While it is set, neither side idles.
  bit quiet = 1'b0;
  int sent  = 0;
  int stall_left = 0;

  deframe_scoreboard sb = new();

  websocket_frame_deframer_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .kind_o           (kind_o),
    .out_byte_o       (out_byte_o),
    .frame_opcode_o   (frame_opcode_o),
    .final_fragment_o (final_fragment_o),
    .frame_done_o     (frame_done_o),
    .error_code_o     (error_code_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Output side. The testbench samples right after the edge, so it sees the values
  // that the edge itself saw, because all of the block's registers update later in
  // the same step. A transfer happens when valid was high and our stall was low.
  // The stall for the next cycle is then chosen at random, in bursts.
  always @(posedge clk_i) begin
    res_t seen;
    if (out_valid_o && !out_stall) begin
      seen.kind   = kind_e'(kind_o);
      seen.data   = out_byte_o;
      seen.opcode = frame_opcode_o;
      seen.fin    = final_fragment_o;
      seen.done   = frame_done_o;
      seen.err    = err_e'(error_code_o);
      sb.check_result(seen);
    end
    if (quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one byte and returns at the edge where the byte transfers. The byte is
  // noted with the scoreboard at that moment. Valid may drop for an idle burst before
  // the byte is offered, but never after the byte is up, so the value held during a
  // stall stays as it is.
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_byte(b);
    sent++;
  endtask

  // Holds off the sender until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Sends one well-formed frame with random payload and, if masked, a random key.
  // Extended lengths are sent in network byte order. Short values in the 16-bit and
  // 64-bit forms are non-minimal encodings, which the block has to accept too.
  task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                            input int len_mode, input logic [63:0] len,
                            input int payload_bytes);
    logic [31:0] mkey;
    mkey = $urandom;
    send_byte({fin, 3'b000, op});
    case (len_mode)
      LEN_MODE_EXT16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      LEN_MODE_EXT64: begin
        send_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(8'(len >> (8 * i)));
      end
      default: send_byte({masked, len[6:0]});
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(8'(mkey >> (8 * i)));
    end
    for (int i = 0; i < payload_bytes; i++) send_byte(8'($urandom));
  endtask

  function automatic logic [3:0] pick_defined_op();
    case ($urandom_range(0, 5))
      0:       return OP_CONT;
      1:       return OP_TEXT;
      2:       return OP_BIN;
      3:       return OP_CLOSE;
      4:       return OP_PING;
      default: return OP_PONG;
    endcase
  endfunction

  task automatic send_random_frame();
    logic [3:0]  op;
    logic [63:0] len;
    int          mode;
    int          r;
    op = pick_defined_op();
    r  = $urandom_range(0, 9);
    // Control frames keep to the short form. Their extended form is an error case,
    // and the run saves that for its end.
    if (op >= OP_CLOSE || r <= 6) begin
      mode = LEN_MODE_SHORT;
      len  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 125))
                                         : 64'($urandom_range(0, 12));
    end else begin
      mode = (r == 9) ? LEN_MODE_EXT64 : LEN_MODE_EXT16;
      len  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 3))
                                         : 64'($urandom_range(0, 150));
    end
    send_frame(1'($urandom), op, 1'($urandom), mode, len, int'(len));
  endtask

  // The last item of the run. It is one of the sticky errors followed by noise, or
  // else a frame whose 64-bit length has its top bit set, so that it never ends.
  task automatic send_ending();
    int          pick;
    int          r;
    logic [63:0] len;
    pick = $urandom_range(END_RSV_BIT, END_HUGE_LEN);
    case (pick)
      END_RSV_BIT: begin
        send_byte({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)});
      end
      END_RSV_OP: begin
        r = $urandom_range(0, 9);
        send_byte({1'($urandom), 3'b000, (r < 5) ? 4'(3 + r) : 4'(6 + r)});
      end
      END_CTRL_EXT: begin
        send_byte({1'($urandom), 3'b000, 4'($urandom_range(8, 10))});
        send_byte({1'($urandom), ($urandom_range(0, 1) == 0) ? LEN_EXT16 : LEN_EXT64});
      end
      default: begin
        len = {1'b1, 31'($urandom), 32'($urandom)};
        send_frame(1'($urandom), OP_BIN, 1'($urandom), LEN_MODE_EXT64, len, NOISE_BYTES);
      end
    endcase
    // Once the block has failed, every byte gets the stored error back. Fully random
    // bytes here also look like the start of new frames.
    if (pick != END_HUGE_LEN) begin
      for (int i = 0; i < NOISE_BYTES; i++) send_byte(8'($urandom));
    end
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);
    drain_results();

    // The random part is mostly well-formed frames, with random content and random
    // header choices. At one point the sender waits for the block to drain fully.
    while (sent < RANDOM_ITEMS) begin
      if (!paused && sent >= PAUSE_AT) begin
        drain_results();
        paused = 1'b1;
      end
      if (sent >= QUIET_FROM) quiet = 1'b1;
      send_random_frame();
    end
    quiet = 1'b1;
    send_ending();
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    // Keep watching the output for any result that the block should not produce.
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("websocket_frame_deframer_unit_tb: done, clean");
    end else begin
      $display("websocket_frame_deframer_unit_tb: done, errors");
    end
    $finish;
  end

  // Run limit. A correct run finishes well within it, even when every byte waits
  // out the longest gap and the longest stall.
  initial begin
    #3000000;
    $display("websocket_frame_deframer_unit_tb: done, errors");
    $finish;
  end

endmodule
